>>> rtl/core/gtes_pkg.sv
package gtes_pkg;

    localparam int LEN_W       = 16;
    localparam int FADE_W      = 15;
    localparam int RECIP_W     = 17;
    localparam int GAIN_W      = 16;
    localparam int CNT_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LEN_W-1:0]  LEN_MIN     = LEN_W'(64);
    localparam logic [GAIN_W-1:0] GAIN_UNITY  = GAIN_W'(4096);
    localparam int                GAIN_SHIFT  = 12;
    localparam int                RAMP_SHIFT  = 16;

    // floor(4*x3/27) as (4*x3 * DIV_RECIP) >> DIV_SHIFT, exact below 2**32/5
    localparam int                DIV_RECIP_W = 28;
    localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = DIV_RECIP_W'(159072863);
    localparam int                DIV_SHIFT   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAIN_LENGTH    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_LENGTH     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_RECIPROCAL = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SQUASH_GAIN     = CFG_IDX_W'(3);

    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_ONE  = 2'd1,
        KIND_RAMP = 2'd2
    } kind_t;

    typedef struct packed {
        logic             act;
        kind_t            kind;
        logic [CNT_W-1:0] pos;
    } cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0]   grain_length;
        logic [FADE_W-1:0]  fade_length;
        logic [RECIP_W-1:0] fade_reciprocal;
        logic [GAIN_W-1:0]  squash_gain;
    } cfg_t;

endpackage

>>> rtl/core/gtes_front.sv
module gtes_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  gtes_pkg::cfg_t cfg,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          start_req,
    input  logic          q_full,
    output logic          q_push,
    output gtes_pkg::cmd_t q_cmd
);
    import gtes_pkg::*;

    localparam int CMP_W = CNT_W + 1;

    logic signed [CNT_W-1:0] samples_left_reg;
    logic signed [CNT_W-1:0] samples_left_next;
    logic [LEN_W-1:0]        len_clip;
    logic [LEN_W-1:0]        eff_len;
    logic signed [CNT_W-1:0] d;
    logic signed [CMP_W-1:0] d_e;
    logic signed [CMP_W-1:0] len_e;
    logic signed [CMP_W-1:0] fade_e;
    logic signed [CMP_W-1:0] mid_end;
    logic signed [CMP_W-1:0] fall_pos;

    assign len_clip = (cfg.grain_length < LEN_MIN) ? LEN_MIN : cfg.grain_length;
    assign eff_len  = {len_clip[LEN_W-1:2], 2'b00};

    assign d        = start_req ? $signed({1'b0, eff_len}) : samples_left_reg;
    assign d_e      = {d[CNT_W-1], d};
    assign len_e    = $signed({2'b00, eff_len});
    assign fade_e   = $signed({3'b000, cfg.fade_length});
    assign mid_end  = len_e - fade_e;
    assign fall_pos = len_e - d_e;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // classify the counter position into a zero, flat or ramp sample
    always_comb begin
        q_cmd.act  = !d[CNT_W-1];
        q_cmd.kind = KIND_ZERO;
        q_cmd.pos  = '0;
        if (d[CNT_W-1]) begin
            q_cmd.kind = KIND_ZERO;
        end else if (d_e < fade_e) begin
            q_cmd.kind = KIND_RAMP;
            q_cmd.pos  = d;
        end else if (d_e < mid_end) begin
            q_cmd.kind = KIND_ONE;
        end else if (d_e >= len_e) begin
            q_cmd.kind = KIND_ZERO;
        end else begin
            q_cmd.kind = KIND_RAMP;
            q_cmd.pos  = fall_pos[CNT_W-1:0];
        end
    end

    always_comb begin
        samples_left_next = samples_left_reg;
        if (q_push) begin
            samples_left_next = d[CNT_W-1] ? d : d - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            samples_left_reg <= '1;
        end else begin
            samples_left_reg <= samples_left_next;
        end
    end

    a_count_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (samples_left_reg[CNT_W-1] == 1'b0) || (samples_left_reg == '1))
        else $error("samples left below minus one");

endmodule

>>> rtl/core/gtes_queue.sv
module gtes_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  gtes_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output gtes_pkg::cmd_t pop_cmd
);
    import gtes_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    cmd_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_next;

    assign full    = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign pop_cmd = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (PTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

endmodule

>>> rtl/core/gtes_back.sv
module gtes_back #(
    parameter int ENV_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  gtes_pkg::cfg_t       cfg,
    input  logic                 q_valid,
    input  gtes_pkg::cmd_t       q_cmd,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [ENV_WIDTH-1:0] envelope,
    output logic                 active
);
    import gtes_pkg::*;

    localparam int F   = ENV_WIDTH - 1;
    localparam int X_W = ENV_WIDTH;
    localparam int T_W = ENV_WIDTH + 1;
    localparam int A_W = (T_W + 2 > CNT_W) ? T_W + 2 : CNT_W;
    localparam int B_W = (DIV_RECIP_W > ENV_WIDTH) ? DIV_RECIP_W : ENV_WIDTH;
    localparam int P_W = A_W + B_W;
    localparam int R_W = P_W + F;

    localparam logic [ENV_WIDTH-1:0] ENV_ONE  = {1'b1, {F{1'b0}}};
    localparam logic [X_W-1:0]       CLAMP_HI = {2'b11, {(F-1){1'b0}}};

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_RAMP = 7'b0000010,
        ST_GAIN = 7'b0000100,
        ST_SQR  = 7'b0001000,
        ST_CUBE = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic                  act_reg, act_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic [ENV_WIDTH-1:0]  env_reg, env_next;
    logic [X_W-1:0]        x_reg, x_next;
    logic [T_W-1:0]        t_reg, t_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [ENV_WIDTH-1:0]  envelope_reg, envelope_next;
    logic                  active_reg, active_next;

    logic                  squash_on;
    logic                  out_free;
    logic [A_W-1:0]        mul_a;
    logic [B_W-1:0]        mul_b;
    logic [P_W-1:0]        mul_p;
    logic [R_W-1:0]        ramp_sh;
    logic [ENV_WIDTH-1:0]  ramp_v;
    logic [P_W-1:0]        gain_sh;
    logic [X_W-1:0]        gain_x;
    logic [P_W-1:0]        pow_sh;
    logic [P_W-1:0]        div_sh;
    logic [X_W-1:0]        div_c;
    logic [X_W-1:0]        sq_y;
    logic [ENV_WIDTH-1:0]  sq_env;

    assign squash_on = (cfg.squash_gain > GAIN_UNITY);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;

    // one shared multiplier, operands picked by the sequencer step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_RAMP: begin
                mul_a = A_W'(pos_reg);
                mul_b = B_W'(cfg.fade_reciprocal);
            end
            ST_GAIN: begin
                mul_a = A_W'(cfg.squash_gain);
                mul_b = B_W'(env_reg);
            end
            ST_SQR: begin
                mul_a = A_W'(x_reg);
                mul_b = B_W'(x_reg);
            end
            ST_CUBE: begin
                mul_a = A_W'(t_reg);
                mul_b = B_W'(x_reg);
            end
            ST_DIV: begin
                mul_a = A_W'({t_reg, 2'b00});
                mul_b = B_W'(DIV_RECIP);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = P_W'(mul_a) * P_W'(mul_b);

    assign ramp_sh = {mul_p, {F{1'b0}}} >> RAMP_SHIFT;
    assign ramp_v  = (ramp_sh > R_W'(ENV_ONE)) ? ENV_ONE : ramp_sh[ENV_WIDTH-1:0];

    assign gain_sh = mul_p >> GAIN_SHIFT;
    assign gain_x  = (gain_sh > P_W'(CLAMP_HI)) ? CLAMP_HI : gain_sh[X_W-1:0];

    assign pow_sh  = mul_p >> F;

    assign div_sh  = mul_p >> DIV_SHIFT;
    assign div_c   = div_sh[X_W-1:0];
    assign sq_y    = (div_c > x_reg) ? '0 : x_reg - div_c;
    assign sq_env  = (sq_y > ENV_ONE) ? ENV_ONE : sq_y;

    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        pos_next      = pos_reg;
        env_next      = env_reg;
        x_next        = x_reg;
        t_next        = t_reg;
        m_tvalid_next = m_tvalid_reg;
        envelope_next = envelope_reg;
        active_next   = active_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    act_next = q_cmd.act;
                    pos_next = q_cmd.pos;
                    case (q_cmd.kind)
                        KIND_RAMP: begin
                            state_next = ST_RAMP;
                        end
                        KIND_ONE: begin
                            env_next   = ENV_ONE;
                            state_next = squash_on ? ST_GAIN : ST_DONE;
                        end
                        default: begin
                            env_next   = '0;
                            state_next = squash_on ? ST_GAIN : ST_DONE;
                        end
                    endcase
                end
            end
            ST_RAMP: begin
                env_next   = ramp_v;
                state_next = squash_on ? ST_GAIN : ST_DONE;
            end
            ST_GAIN: begin
                x_next     = gain_x;
                state_next = ST_SQR;
            end
            ST_SQR: begin
                t_next     = pow_sh[T_W-1:0];
                state_next = ST_CUBE;
            end
            ST_CUBE: begin
                t_next     = pow_sh[T_W-1:0];
                state_next = ST_DIV;
            end
            ST_DIV: begin
                env_next   = sq_env;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    envelope_next = env_reg;
                    active_next   = act_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg      <= act_next;
        pos_reg      <= pos_next;
        env_reg      <= env_next;
        x_reg        <= x_next;
        t_reg        <= t_next;
        envelope_reg <= envelope_next;
        active_reg   <= active_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign envelope = envelope_reg;
    assign active   = active_reg;

    a_env_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> envelope_reg <= ENV_ONE)
        else $error("envelope above unity");

    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !active_reg) |-> envelope_reg == '0)
        else $error("finished grain with non-zero envelope");

endmodule

>>> rtl/core/grain_trapezoid_envelope_shaper_core.sv
// Envelope generator for one audio grain, one envelope value per input item.
// s_ channel: each item carries start_req in s_tdata bit 0; 1 reloads the
// samples-left counter from grain_length and restarts the grain, 0 advances
// one sample. m_ channel: one item per input item, envelope in m_tdata
// (Q1.15 at the default width) and the active flag in m_tuser.
// cfg channel: register index and data, always ready; write only while the
// block is idle. Registers: grain_length, fade_length, fade_reciprocal,
// squash_gain.
// The front classifies each item in its accept cycle and pushes it into a
// two-entry queue; the back sequencer works one item at a time on a single
// shared multiplier. The back pops an item in its idle state, passes a ramp
// sample through the ramp step, runs the gain, square, cube and divide steps
// when squash_gain is above unity, and loads the result register from the
// done state; it takes the next item only after returning to idle.
// Reset clears the counter to finished and loads the register defaults.
// A stalled receiver holds the result register; the back finishes the next
// item and waits, and the queue keeps accepting until both entries are full.
module grain_trapezoid_envelope_shaper_core #(
    parameter int ENV_WIDTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] start_req
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [((ENV_WIDTH+7)/8)*8-1:0] m_tdata,   // [ENV_WIDTH-1:0] envelope
    output logic                           m_tuser,   // [0] active
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gtes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gtes_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import gtes_pkg::*;

    localparam int TDATA_W = ((ENV_WIDTH + 7) / 8) * 8;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 q_full;
    logic                 q_push;
    cmd_t                 q_push_cmd;
    logic                 q_pop;
    logic                 q_valid;
    cmd_t                 q_pop_cmd;
    logic [ENV_WIDTH-1:0] envelope;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_GRAIN_LENGTH:    cfg_next.grain_length    = cfg_wdata[LEN_W-1:0];
                CFG_FADE_LENGTH:     cfg_next.fade_length     = cfg_wdata[FADE_W-1:0];
                CFG_FADE_RECIPROCAL: cfg_next.fade_reciprocal = cfg_wdata[RECIP_W-1:0];
                CFG_SQUASH_GAIN:     cfg_next.squash_gain     = cfg_wdata[GAIN_W-1:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grain_length    <= LEN_W'(64);
            cfg_reg.fade_length     <= '0;
            cfg_reg.fade_reciprocal <= '0;
            cfg_reg.squash_gain     <= GAIN_UNITY;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    gtes_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .start_req (s_tdata[0]),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_push_cmd)
    );

    gtes_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (q_pop_cmd)
    );

    gtes_back #(
        .ENV_WIDTH (ENV_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_cmd    (q_pop_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .envelope (envelope),
        .active   (m_tuser)
    );

    assign m_tdata = TDATA_W'(envelope);

endmodule
